@@ hdl/rpb_pkg.sv @@
package rpb_pkg;

  // channel and color geometry
  localparam int unsigned RpbChan     = 5;
  localparam int unsigned RpbNumChan  = 3;
  localparam int unsigned RpbColorW   = RpbChan * RpbNumChan;
  localparam int unsigned RpbInColorW = 16;
  localparam int unsigned RpbCfgW     = 8;
  localparam int unsigned RpbFracBits = 8;

  // divider: numerator is |t-s| << 8, padded to RpbDivW bits
  localparam int unsigned RpbDivW         = 16;
  localparam int unsigned RpbDivStages    = 4;
  localparam int unsigned RpbBitsPerStage = RpbDivW / RpbDivStages;
  localparam int unsigned RpbDivPad       = RpbDivW - RpbChan - RpbFracBits;

  // signed per-step increment and its product with the step count
  localparam int unsigned RpbPerW  = RpbChan + RpbFracBits + 1;
  localparam int unsigned RpbProdW = RpbPerW + RpbCfgW + 1;

  // queue between front and back
  localparam int unsigned RpbFifoDepth = 4;

  // register map (word index) and reset values
  localparam logic RegTotalSteps  = 1'b0;
  localparam logic RegCurrentStep = 1'b1;
  localparam logic [RpbCfgW-1:0] TotalStepsRst  = 8'd16;
  localparam logic [RpbCfgW-1:0] CurrentStepRst = 8'd0;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_TARGET = 2'd1,
    MODE_BLEND  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [RpbCfgW-1:0] total_steps;
    logic [RpbCfgW-1:0] current_step;
  } cfg_t;

  // one classified item as it sits in the queue
  typedef struct packed {
    mode_e                                mode;
    logic [RpbColorW-1:0]                 start;
    logic [RpbColorW-1:0]                 target;
    logic [RpbNumChan-1:0][RpbChan-1:0]   mag;
    logic [RpbNumChan-1:0]                neg;
    logic                                 last;
  } q_entry_t;

  // restoring divider state for one channel
  typedef struct packed {
    logic [RpbCfgW-1:0] rem;
    logic [RpbDivW-1:0] num;
    logic [RpbDivW-1:0] quo;
  } div_acc_t;

  typedef struct packed {
    mode_e                           mode;
    logic [RpbColorW-1:0]            start;
    logic [RpbColorW-1:0]            target;
    logic [RpbNumChan-1:0]           neg;
    logic                            last;
    div_acc_t [RpbNumChan-1:0]       acc;
  } div_stage_t;

  typedef struct packed {
    mode_e                                mode;
    logic [RpbColorW-1:0]                 start;
    logic [RpbColorW-1:0]                 target;
    logic                                 last;
    logic [RpbNumChan-1:0][RpbProdW-1:0]  prod;
  } prod_stage_t;

  // a few quotient bits of restoring division, MSB first
  function automatic div_acc_t div_iter(div_acc_t a, logic [RpbCfgW-1:0] d);
    div_acc_t   r;
    logic [RpbCfgW:0] sh;
    logic       qb;
    r = a;
    for (int i = 0; i < RpbBitsPerStage; i++) begin
      sh = {r.rem, r.num[RpbDivW-1]};
      r.num = {r.num[RpbDivW-2:0], 1'b0};
      qb = 1'b0;
      if (sh >= {1'b0, d}) begin
        sh = sh - {1'b0, d};
        qb = 1'b1;
      end
      r.rem = sh[RpbCfgW-1:0];
      r.quo = {r.quo[RpbDivW-2:0], qb};
    end
    return r;
  endfunction

endpackage

@@ hdl/rpb_if.sv @@
interface rpb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] start_color;
  logic [15:0] target_color;
  logic        last_in;

  modport source (output valid, output start_color, output target_color, output last_in,
                  input ready);
  modport sink   (input valid, input start_color, input target_color, input last_in,
                  output ready);
endinterface

interface rpb_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] blended_color;
  logic        last_out;

  modport source (output valid, output blended_color, output last_out, input ready);
  modport sink   (input valid, input blended_color, input last_out, output ready);
endinterface

@@ hdl/rpb_front.sv @@
module rpb_front (
  rpb_in_if.sink           in_i,
  input  rpb_pkg::cfg_t    cfg_i,
  input  logic             full_i,
  output logic             push_o,
  output rpb_pkg::q_entry_t entry_o
);
  import rpb_pkg::*;

  logic [RpbColorW-1:0] s_col, t_col;
  logic [RpbChan-1:0]   s_c, t_c;

  assign s_col = in_i.start_color[RpbColorW-1:0];
  assign t_col = in_i.target_color[RpbColorW-1:0];

  // transfer whenever the queue has room
  assign in_i.ready = ~full_i;
  assign push_o     = in_i.valid & ~full_i;

  // classify by step and split the channel differences into sign and magnitude
  always_comb begin
    s_c = '0;
    t_c = '0;
    entry_o.start  = s_col;
    entry_o.target = t_col;
    entry_o.last   = in_i.last_in;
    if (cfg_i.current_step == '0) begin
      entry_o.mode = MODE_START;
    end else if (cfg_i.current_step >= cfg_i.total_steps) begin
      entry_o.mode = MODE_TARGET;
    end else begin
      entry_o.mode = MODE_BLEND;
    end
    for (int c = 0; c < RpbNumChan; c++) begin
      s_c = s_col[c*RpbChan +: RpbChan];
      t_c = t_col[c*RpbChan +: RpbChan];
      entry_o.neg[c] = (t_c < s_c);
      entry_o.mag[c] = (t_c < s_c) ? (s_c - t_c) : (t_c - s_c);
    end
  end

endmodule

@@ hdl/rpb_fifo.sv @@
module rpb_fifo #(
  parameter int unsigned Depth = rpb_pkg::RpbFifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rpb_pkg::q_entry_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rpb_pkg::q_entry_t rdata_o
);
  import rpb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ hdl/rpb_back.sv @@
module rpb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpb_pkg::cfg_t     cfg_i,
  input  logic              valid_i,
  input  rpb_pkg::q_entry_t entry_i,
  output logic              pop_o,
  rpb_out_if.source         out_o
);
  import rpb_pkg::*;

  div_stage_t                div_first;
  div_stage_t                div_q [RpbDivStages];
  div_stage_t                div_d [RpbDivStages];
  logic [RpbDivStages-1:0]   div_vld_q, div_rdy;

  prod_stage_t               prd_q, prd_d;
  logic                      prd_vld_q, prd_rdy;

  logic                      out_vld_q, out_rdy;
  logic [RpbColorW-1:0]      out_col_q, out_col_d;
  logic                      out_last_q;

  logic signed [RpbPerW-1:0]  per;
  logic signed [RpbCfgW:0]    stp;
  logic [RpbPerW-1:0]         pq;
  logic [RpbChan-1:0]         ch;
  logic [RpbColorW-1:0]       blend;

  // elastic ready chain, output register first
  always_comb begin
    out_rdy = ~out_vld_q | out_o.ready;
    prd_rdy = ~prd_vld_q | out_rdy;
    div_rdy[RpbDivStages-1] = ~div_vld_q[RpbDivStages-1] | prd_rdy;
    for (int k = RpbDivStages - 2; k >= 0; k--) begin
      div_rdy[k] = ~div_vld_q[k] | div_rdy[k+1];
    end
  end

  assign pop_o = valid_i & div_rdy[0];

  // seed the dividers: numerator is |t-s| with 8 fraction bits
  always_comb begin
    div_first.mode   = entry_i.mode;
    div_first.start  = entry_i.start;
    div_first.target = entry_i.target;
    div_first.neg    = entry_i.neg;
    div_first.last   = entry_i.last;
    for (int c = 0; c < RpbNumChan; c++) begin
      div_first.acc[c].rem = '0;
      div_first.acc[c].quo = '0;
      div_first.acc[c].num = {RpbDivPad'(0), entry_i.mag[c], RpbFracBits'(0)};
    end
  end

  // divider stages, a few quotient bits each
  always_comb begin
    for (int k = 0; k < RpbDivStages; k++) begin
      div_d[k] = (k == 0) ? div_first : div_q[(k == 0) ? 0 : k - 1];
      for (int c = 0; c < RpbNumChan; c++) begin
        div_d[k].acc[c] = div_iter(div_d[k].acc[c], cfg_i.total_steps);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q <= '0;
    end else begin
      for (int k = 0; k < RpbDivStages; k++) begin
        if (div_rdy[k]) begin
          div_vld_q[k] <= (k == 0) ? valid_i : div_vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RpbDivStages; k++) begin
      if (div_rdy[k]) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // signed increment per step times the current step
  always_comb begin
    pq  = '0;
    per = '0;
    stp = $signed({1'b0, cfg_i.current_step});
    prd_d.mode   = div_q[RpbDivStages-1].mode;
    prd_d.start  = div_q[RpbDivStages-1].start;
    prd_d.target = div_q[RpbDivStages-1].target;
    prd_d.last   = div_q[RpbDivStages-1].last;
    for (int c = 0; c < RpbNumChan; c++) begin
      pq  = {1'b0, div_q[RpbDivStages-1].acc[c].quo[RpbPerW-2:0]};
      per = div_q[RpbDivStages-1].neg[c] ? $signed(-pq) : $signed(pq);
      prd_d.prod[c] = RpbProdW'(per * stp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_vld_q <= 1'b0;
    end else if (prd_rdy) begin
      prd_vld_q <= div_vld_q[RpbDivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prd_rdy) begin
      prd_q <= prd_d;
    end
  end

  // floor shift by 8 and add, wrapping per channel; then pick by mode
  always_comb begin
    ch    = '0;
    blend = '0;
    for (int c = 0; c < RpbNumChan; c++) begin
      ch = prd_q.start[c*RpbChan +: RpbChan] + prd_q.prod[c][RpbFracBits +: RpbChan];
      blend[c*RpbChan +: RpbChan] = ch;
    end
    case (prd_q.mode)
      MODE_START:  out_col_d = prd_q.start;
      MODE_TARGET: out_col_d = prd_q.target;
      MODE_BLEND:  out_col_d = blend;
      default:     out_col_d = blend;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= prd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      out_col_q  <= out_col_d;
      out_last_q <= prd_q.last;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.blended_color = out_col_q;
  assign out_o.last_out      = out_last_q;

endmodule

@@ hdl/rgb555_palette_blend_top.sv @@
// RGB555 fade step.
// in_i carries a start and a target color (bit 15 ignored) plus a last flag;
// out_o returns the color at current_step of a fade total_steps long, with
// the last flag copied. Both channels use valid/ready; a transfer happens
// when both are high. One result per input, in order.
// Registers sit on the APB port: total_steps at 0x0, current_step at 0x4,
// low 8 bits kept; write them only while no items are in flight.
// Throughput: one item per cycle while out_o.ready stays high. After the
// input transfer an item passes through the queue, four pipelined divider
// stages (4 quotient bits each), one multiply stage and the output
// register.
// When the receiver stalls, the pipeline stages fill up behind the output
// register and then the queue (FifoDepth entries) absorbs further items
// before in_i.ready drops.
// Reset empties the queue and pipeline and sets total_steps to 16 and
// current_step to 0.
module rgb555_palette_blend_top #(
  parameter int unsigned FifoDepth = rpb_pkg::RpbFifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rpb_in_if.sink      in_i,
  rpb_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rpb_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  logic     reg_idx;
  logic     push, full, pop, q_valid;
  q_entry_t q_wdata, q_rdata;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegTotalSteps:  cfg_d.total_steps  = pwdata[RpbCfgW-1:0];
        RegCurrentStep: cfg_d.current_step = pwdata[RpbCfgW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_steps  <= TotalStepsRst;
      cfg_q.current_step <= CurrentStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      RegTotalSteps:  prdata = {(32 - RpbCfgW)'(0), cfg_q.total_steps};
      RegCurrentStep: prdata = {(32 - RpbCfgW)'(0), cfg_q.current_step};
      default:        prdata = '0;
    endcase
  end

  rpb_front u_front (
    .in_i    (in_i),
    .cfg_i   (cfg_q),
    .full_i  (full),
    .push_o  (push),
    .entry_o (q_wdata)
  );

  rpb_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  rpb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (q_valid),
    .entry_i (q_rdata),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
